### rtl/core/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, codes and constants of the descent deployment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

   localparam int unsigned DDS_LOG_TABLE_DEPTH = 64;

   // flight modes
   localparam logic [2:0] MODE_READY     = 3'd0;
   localparam logic [2:0] MODE_LOADED    = 3'd1;
   localparam logic [2:0] MODE_FREE_FALL = 3'd2;
   localparam logic [2:0] MODE_AWAIT     = 3'd3;
   localparam logic [2:0] MODE_PRELAND   = 3'd4;
   localparam logic [2:0] MODE_LANDED    = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_GROUND_PRESSURE = 3'd0;
   localparam logic [2:0] CSR_LIGHT_RELEASE   = 3'd1;
   localparam logic [2:0] CSR_SONAR_RELEASE   = 3'd2;
   localparam logic [2:0] CSR_CHUTE_ALTITUDE  = 3'd3;
   localparam logic [2:0] CSR_PRELAND_ALT     = 3'd4;
   localparam logic [2:0] CSR_CHUTE_TIMEOUT   = 3'd5;
   localparam logic [2:0] CSR_STILL_SPEED     = 3'd6;
   localparam logic [2:0] CSR_TOUCHDOWN_SONAR = 3'd7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;

   localparam logic [31:0] ALT_SCALE      = 32'd3831535436;
   localparam logic [28:0] TSEC_RECIP     = 29'd274877907;
   localparam int unsigned TSEC_SHIFT     = 38;
   localparam int unsigned TSEC_W         = 23;
   localparam logic [7:0]  STILL_SAMPLES  = 8'd10;
   localparam logic [6:0]  CUT_HEIGHT_DM  = 7'd100;
   localparam int unsigned DIV_NUM_W      = 39;
   localparam int unsigned DIV_DEN_W      = 16;

   typedef struct packed {
      logic capture;
      logic log_sel;
      logic store_lg0;
      logic store_lg1;
      logic store_alt;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
   } ctrl_status_type;

   // log2(m) fraction for a Q2.30 mantissa in [1,2], by repeated squaring
   function automatic logic [24:0] log2_frac(input logic [63:0] m_in);
      logic [63:0] m;
      logic [24:0] r;
      m = m_in;
      r = '0;
      if (m >= (64'd1 << 31)) begin
         r = 25'd1 << 24;
      end else begin
         for (int k = 23; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               r[k] = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/dds_div.sv
// ----------------------------------------------------------------------------
// dds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dds_pkg::DIV_NUM_W-1:0]   dividend,
   input  logic [dds_pkg::DIV_DEN_W-1:0]   divisor,
   output logic                            busy,
   output logic [dds_pkg::DIV_NUM_W-1:0]   quotient
);
   import dds_pkg::*;

   localparam int unsigned CntW = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DIV_DEN_W+1:0] trial;

   assign trial = {1'b0, rem_ff, quo_ff[DIV_NUM_W-1]} - {2'b00, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntW'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_DEN_W+1]) begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_DEN_W-2:0], quo_ff[DIV_NUM_W-1]};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/core/dds_ctrl.sv
// ----------------------------------------------------------------------------
// dds_ctrl
// Step sequencer: log passes, altitude, divide, decision and result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dds_pkg::ctrl_cmd_type     cmd,
   input  dds_pkg::ctrl_status_type  status
);
   import dds_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_L0   = 4'd1;
   localparam logic [3:0] ST_L1   = 4'd2;
   localparam logic [3:0] ST_L2   = 4'd3;
   localparam logic [3:0] ST_L3   = 4'd4;
   localparam logic [3:0] ST_L4   = 4'd5;
   localparam logic [3:0] ST_L5   = 4'd6;
   localparam logic [3:0] ST_A0   = 4'd7;
   localparam logic [3:0] ST_A1   = 4'd8;
   localparam logic [3:0] ST_A2   = 4'd9;
   localparam logic [3:0] ST_DS   = 4'd10;
   localparam logic [3:0] ST_DW   = 4'd11;
   localparam logic [3:0] ST_DEC  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.log_sel = (state_ff == ST_L3) || (state_ff == ST_L4) || (state_ff == ST_L5);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_L0;
         end
         ST_L0: state_in = ST_L1;
         ST_L1: state_in = ST_L2;
         ST_L2: begin
            cmd.store_lg0 = 1'b1;
            state_in = ST_L3;
         end
         ST_L3: state_in = ST_L4;
         ST_L4: state_in = ST_L5;
         ST_L5: begin
            cmd.store_lg1 = 1'b1;
            state_in = ST_A0;
         end
         ST_A0: state_in = ST_A1;
         ST_A1: begin
            cmd.store_alt = 1'b1;
            state_in = ST_A2;
         end
         ST_A2: state_in = ST_DS;
         ST_DS: begin
            cmd.div_start = 1'b1;
            state_in = ST_DW;
         end
         ST_DW: begin
            if (!status.div_busy) state_in = ST_DEC;
         end
         ST_DEC: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

### rtl/core/dds_path.sv
// ----------------------------------------------------------------------------
// dds_path
// Datapath: registers, fixed-point log, altitude, descent math, flight mode.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_path #(
   parameter int unsigned LOG_TABLE_DEPTH = dds_pkg::DDS_LOG_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dds_pkg::ctrl_cmd_type              cmd,
   output dds_pkg::ctrl_status_type           status,
   input  logic [31:0]                        req_time_ms,
   input  logic                               req_command_seen,
   input  logic [15:0]                        req_light_level,
   input  logic [16:0]                        req_pressure_pa,
   input  logic [15:0]                        req_sonar_cm,
   input  logic                               csr_write_enable,
   input  logic [dds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [2:0]                         rsp_flight_state,
   output logic                               rsp_fire_chute,
   output logic                               rsp_fire_legs,
   output logic                               rsp_fire_cut,
   output logic [15:0]                        rsp_cut_delay_ms,
   output logic signed [15:0]                 rsp_altitude_dm
);
   import dds_pkg::*;

   localparam int unsigned IdxW = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int unsigned PosW = 30 + IdxW;

   // configuration
   logic [16:0] gnd_p_ff;
   logic [15:0] light_rel_ff, sonar_rel_ff, td_sonar_ff;
   logic [14:0] chute_alt_ff, preland_alt_ff;
   logic [7:0]  timeout_ff;
   logic [9:0]  still_spd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gnd_p_ff       <= 17'd101325;
         light_rel_ff   <= 16'd400;
         sonar_rel_ff   <= 16'd50;
         chute_alt_ff   <= 15'd2500;
         preland_alt_ff <= 15'd500;
         timeout_ff     <= 8'd30;
         still_spd_ff   <= 10'd100;
         td_sonar_ff    <= 16'd12;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GROUND_PRESSURE: gnd_p_ff       <= csr_wdata;
            CSR_LIGHT_RELEASE:   light_rel_ff   <= csr_wdata[15:0];
            CSR_SONAR_RELEASE:   sonar_rel_ff   <= csr_wdata[15:0];
            CSR_CHUTE_ALTITUDE:  chute_alt_ff   <= csr_wdata[14:0];
            CSR_PRELAND_ALT:     preland_alt_ff <= csr_wdata[14:0];
            CSR_CHUTE_TIMEOUT:   timeout_ff     <= csr_wdata[7:0];
            CSR_STILL_SPEED:     still_spd_ff   <= csr_wdata[9:0];
            CSR_TOUCHDOWN_SONAR: td_sonar_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // captured transaction
   logic [31:0] t_ms_ff;
   logic        cmd_seen_ff;
   logic [15:0] light_ff, sonar_ff;
   logic [16:0] press_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ms_ff     <= req_time_ms;
         cmd_seen_ff <= req_command_seen;
         light_ff    <= req_light_level;
         press_ff    <= req_pressure_pa;
         sonar_ff    <= req_sonar_cm;
      end
   end

   // log2 fraction table
   logic [24:0] log_tab [0:LOG_TABLE_DEPTH];

   for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_tab
      localparam logic [63:0] TabM = (64'd1 << 30) + ((64'(g) << 30) / LOG_TABLE_DEPTH);
      localparam logic [24:0] TabVal = log2_frac(TabM);
      assign log_tab[g] = TabVal;
   end

   // log stage a: normalize, index, table read
   logic [16:0]     lx;
   logic [4:0]      la_e_in, la_e_ff;
   logic [46:0]     norm;
   logic [PosW-1:0] pos;
   logic [IdxW-1:0] idx_raw, idx;
   logic [24:0]     la_lo_in, la_lo_ff, la_diff_in, la_diff_ff;
   logic [29:0]     la_rem_in, la_rem_ff;

   assign lx = cmd.log_sel ? press_ff : gnd_p_ff;

   always_comb begin
      la_e_in = '0;
      for (int i = 0; i < 17; i++) begin
         if (lx[i]) la_e_in = 5'(i);
      end
   end

   assign norm      = 47'(lx) << (5'd30 - la_e_in);
   assign pos       = PosW'(norm[29:0]) * PosW'(LOG_TABLE_DEPTH);
   assign idx_raw   = pos[PosW-1:30];
   assign idx       = (idx_raw >= IdxW'(LOG_TABLE_DEPTH)) ?
                      IdxW'(LOG_TABLE_DEPTH - 1) : idx_raw;
   assign la_rem_in = pos[29:0];
   assign la_lo_in  = log_tab[idx];
   assign la_diff_in = log_tab[idx + 1'b1] - log_tab[idx];

   // log stage b: interpolation product
   logic [4:0]  lb_e_ff;
   logic [24:0] lb_lo_ff, lb_interp_in, lb_interp_ff;
   logic [54:0] lb_prod;

   assign lb_prod      = 55'(la_diff_ff) * 55'(la_rem_ff);
   assign lb_interp_in = lb_prod[54:30];

   // log stage c: sum
   logic [29:0] lg_sum, lg0_ff, lg1_ff;

   assign lg_sum = (30'(lb_e_ff) << 24) + 30'(lb_lo_ff) + 30'(lb_interp_ff);

   // altitude scaling
   logic signed [30:0] lg_diff;
   logic [29:0]        sc_mag;
   logic [61:0]        sc_prod_in, sc_prod_ff;
   logic               sc_neg_ff;
   logic [61:0]        sc_round;
   logic [21:0]        sc_q;
   logic signed [15:0] alt_in, alt_ff;

   assign lg_diff    = $signed({1'b0, lg0_ff}) - $signed({1'b0, lg1_ff});
   assign sc_mag     = lg_diff[30] ? 30'(-lg_diff) : 30'(lg_diff);
   assign sc_prod_in = 62'(sc_mag) * 62'(ALT_SCALE);
   assign sc_round   = sc_prod_ff + (62'd1 << 39);
   assign sc_q       = sc_round[61:40];

   always_comb begin
      if (press_ff == '0) begin
         alt_in = 16'sd32767;
      end else if (gnd_p_ff == '0) begin
         alt_in = -16'sd32768;
      end else if (sc_neg_ff) begin
         alt_in = (sc_q >= 22'd32768) ? -16'sd32768 : -$signed(16'(sc_q));
      end else begin
         alt_in = (sc_q > 22'd32767) ? 16'sd32767 : $signed(16'(sc_q));
      end
   end

   // flight state
   logic [2:0]         mode_ff, mode_in;
   logic [TSEC_W-1:0]  cft_ff, cft_in;
   logic signed [15:0] last_alt_ff, last_alt_in;
   logic [31:0]        last_t_ff, last_t_in;
   logic               last_valid_ff, last_valid_in;
   logic [7:0]         still_ff, still_in;

   // descent products
   logic signed [16:0] da, s_in, s_ff;
   logic [16:0]        abs_da;
   logic [31:0]        dt;
   logic [26:0]        mag_in, mag_ff;
   logic [41:0]        bound_in, bound_ff;
   logic [DIV_NUM_W-1:0] num_in, num_ff;
   logic [60:0]        tsec_prod;
   logic [TSEC_W-1:0]  tsec_in, tsec_ff;

   assign da       = 17'(alt_ff) - 17'(last_alt_ff);
   assign abs_da   = da[16] ? 17'(-da) : 17'(da);
   assign dt       = t_ms_ff - last_t_ff;
   assign mag_in   = 27'(abs_da) * 27'd1000;
   assign bound_in = 42'(still_spd_ff) * 42'(dt);
   assign num_in   = DIV_NUM_W'(dt) * DIV_NUM_W'(CUT_HEIGHT_DM);
   assign s_in     = 17'(last_alt_ff) - 17'(alt_ff);
   assign tsec_prod = 61'(t_ms_ff) * 61'(TSEC_RECIP);
   assign tsec_in  = tsec_prod[TSEC_SHIFT + TSEC_W - 1:TSEC_SHIFT];

   logic [DIV_NUM_W-1:0] div_q;
   logic                 div_busy;

   dds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (s_ff[15:0]),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign status.div_busy = div_busy;

   always_ff @(posedge clock) begin
      la_e_ff      <= la_e_in;
      la_lo_ff     <= la_lo_in;
      la_diff_ff   <= la_diff_in;
      la_rem_ff    <= la_rem_in;
      lb_e_ff      <= la_e_ff;
      lb_lo_ff     <= la_lo_ff;
      lb_interp_ff <= lb_interp_in;
      sc_prod_ff   <= sc_prod_in;
      sc_neg_ff    <= lg_diff[30];
      mag_ff       <= mag_in;
      bound_ff     <= bound_in;
      num_ff       <= num_in;
      s_ff         <= s_in;
      tsec_ff      <= tsec_in;
      if (cmd.store_lg0) lg0_ff <= lg_sum;
      if (cmd.store_lg1) lg1_ff <= lg_sum;
      if (cmd.store_alt) alt_ff <= alt_in;
   end

   // mode decision
   logic        chute_in, legs_in, cut_in, in_await;
   logic [15:0] delay_in;
   logic        s_pos;

   assign s_pos = !s_ff[16] && (s_ff != '0);

   always_comb begin
      mode_in       = mode_ff;
      cft_in        = cft_ff;
      last_alt_in   = last_alt_ff;
      last_t_in     = last_t_ff;
      last_valid_in = last_valid_ff;
      still_in      = still_ff;
      chute_in      = 1'b0;
      legs_in       = 1'b0;
      cut_in        = 1'b0;
      delay_in      = '0;
      in_await      = 1'b0;
      if (mode_in == MODE_READY && cmd_seen_ff) mode_in = MODE_LOADED;
      if (mode_in == MODE_AWAIT && tsec_ff >= cft_ff &&
          (tsec_ff - cft_ff) > TSEC_W'(timeout_ff)) mode_in = MODE_PRELAND;
      if (mode_in == MODE_LOADED && light_ff >= light_rel_ff) mode_in = MODE_FREE_FALL;
      if (mode_in == MODE_FREE_FALL && alt_ff <= $signed({1'b0, chute_alt_ff})) begin
         chute_in = 1'b1;
         cft_in   = tsec_ff;
         mode_in  = MODE_AWAIT;
      end
      if (mode_in == MODE_AWAIT && alt_ff <= $signed({1'b0, preland_alt_ff}))
         mode_in = MODE_PRELAND;
      if (mode_in == MODE_AWAIT) begin
         in_await = 1'b1;
         if (last_valid_ff) begin
            if (42'(mag_ff) < bound_ff) begin
               if (still_ff != 8'hFF) still_in = still_ff + 8'd1;
            end else begin
               still_in = '0;
            end
            if (still_in == STILL_SAMPLES) begin
               legs_in = 1'b1;
               mode_in = MODE_PRELAND;
            end
         end
         last_alt_in   = alt_ff;
         last_t_in     = t_ms_ff;
         last_valid_in = 1'b1;
      end
      if (mode_in == MODE_LOADED && sonar_ff > sonar_rel_ff) mode_in = MODE_FREE_FALL;
      if (mode_in == MODE_PRELAND) begin
         if (sonar_ff < td_sonar_ff) begin
            // after an await pass the previous sample is this one: no descent
            if (!in_await && last_valid_ff && s_pos) begin
               delay_in = (|div_q[DIV_NUM_W-1:16]) ? 16'hFFFF : div_q[15:0];
            end
            cut_in  = 1'b1;
            mode_in = MODE_LANDED;
         end
         last_alt_in   = alt_ff;
         last_t_in     = t_ms_ff;
         last_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_READY;
         cft_ff        <= '0;
         last_alt_ff   <= '0;
         last_t_ff     <= '0;
         last_valid_ff <= 1'b0;
         still_ff      <= '0;
      end else if (cmd.commit) begin
         mode_ff       <= mode_in;
         cft_ff        <= cft_in;
         last_alt_ff   <= last_alt_in;
         last_t_ff     <= last_t_in;
         last_valid_ff <= last_valid_in;
         still_ff      <= still_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_flight_state <= mode_in;
         rsp_fire_chute   <= chute_in;
         rsp_fire_legs    <= legs_in;
         rsp_fire_cut     <= cut_in;
         rsp_cut_delay_ms <= delay_in;
         rsp_altitude_dm  <= alt_ff;
      end
   end

endmodule

`default_nettype wire

### rtl/core/descent_deployment_sequencer.sv
// ----------------------------------------------------------------------------
// descent_deployment_sequencer
// Flight-state sequencer for a descending probe: altitude from pressure,
// stillness count, chute, legs and cut pulses with touchdown delay.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   time, command, light, pressure, sonar
//  rsp_      out        rsp_valid/rsp_ready   state, three pulses, delay, altitude
//  csr_      in         csr_write_enable      csr_index, csr_wdata
//
//  a transaction runs from accept to result valid through two passes of
//  a three-stage log pipeline, three altitude/product steps, the divider
//  start, the restoring divider and a wait state to see it done, and the
//  commit, which waits for a free result slot; req_ready is high only while
//  idle, so a new transaction is not accepted until the previous one commits.
//  the result sits in an output register, so a new transaction is accepted
//  while the previous result waits for rsp_ready.
//  synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module descent_deployment_sequencer #(
   parameter int unsigned LOG_TABLE_DEPTH = dds_pkg::DDS_LOG_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [31:0]                      req_time_ms,
   input  logic                             req_command_seen,
   input  logic [15:0]                      req_light_level,
   input  logic [16:0]                      req_pressure_pa,
   input  logic [15:0]                      req_sonar_cm,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_flight_state,
   output logic                             rsp_fire_chute,
   output logic                             rsp_fire_legs,
   output logic                             rsp_fire_cut,
   output logic [15:0]                      rsp_cut_delay_ms,
   output logic signed [15:0]               rsp_altitude_dm,
   input  logic                             csr_write_enable,
   input  logic [dds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dds_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   dds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dds_path #(
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_path (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_time_ms      (req_time_ms),
      .req_command_seen (req_command_seen),
      .req_light_level  (req_light_level),
      .req_pressure_pa  (req_pressure_pa),
      .req_sonar_cm     (req_sonar_cm),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_flight_state (rsp_flight_state),
      .rsp_fire_chute   (rsp_fire_chute),
      .rsp_fire_legs    (rsp_fire_legs),
      .rsp_fire_cut     (rsp_fire_cut),
      .rsp_cut_delay_ms (rsp_cut_delay_ms),
      .rsp_altitude_dm  (rsp_altitude_dm)
   );

   // busy right after an accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a transaction is in progress");

   // chute and legs never fire in the same pass
   a_chute_legs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fire_chute && rsp_fire_legs))
      else $error("chute and legs fired together");

   // cut lands the probe
   a_cut_landed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fire_cut) |-> (rsp_flight_state == MODE_LANDED))
      else $error("cut without landed state");

   // delay only with a cut
   a_delay_cut: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fire_cut) |-> (rsp_cut_delay_ms == 16'd0))
      else $error("cut delay without cut");

endmodule

`default_nettype wire
